FILE: src/metaball_pixel_shader_top_defines.svh
// Assertion macros for the metaball pixel shader checker.
// Depends on nothing; the using module must provide i_clk and i_rst_n.
`ifndef METABALL_PIXEL_SHADER_TOP_DEFINES_SVH
`define METABALL_PIXEL_SHADER_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define MPS_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("metaball shader check failed");

// Next-cycle implication.
`define MPS_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("metaball shader check failed");

`endif

FILE: src/mps_pkg.sv
// Shared types, constants and the arctangent step table of the metaball shader.
// Used by the controller, the datapath and the top level.
package mps_pkg;

    localparam int MPS_MAX_BLOBS   = 8;
    localparam int MPS_IDX_W       = $clog2(MPS_MAX_BLOBS);
    localparam int MPS_SUPERSAMPLE = 2;
    localparam int MPS_STEP_W      = 6;

    localparam logic [MPS_STEP_W-1:0] MPS_SQRT_LAST = 6'd16;
    localparam logic [MPS_STEP_W-1:0] MPS_DDIV_LAST = 6'd24;
    localparam logic [MPS_STEP_W-1:0] MPS_CDIV_LAST = 6'd40;
    localparam logic [MPS_STEP_W-1:0] MPS_ATAN_LAST = 6'd15;

    localparam logic [15:0] MPS_THRESH    = 16'd51;
    localparam logic [15:0] MPS_FIELD_MAX = 16'hFFFF;

    localparam logic [1:0] MPS_REG_COLOR = 2'd0;
    localparam logic [1:0] MPS_REG_SCALE = 2'd1;
    localparam logic [1:0] MPS_REG_COUNT = 2'd2;

    typedef enum logic [16:0] {
        S_IDLE  = 17'h00001,
        S_DIFF  = 17'h00002,
        S_SQX   = 17'h00004,
        S_SQY   = 17'h00008,
        S_SQRT  = 17'h00010,
        S_DINIT = 17'h00020,
        S_DDIV  = 17'h00040,
        S_CHK   = 17'h00080,
        S_CUBE1 = 17'h00100,
        S_CUBE2 = 17'h00200,
        S_DEN   = 17'h00400,
        S_CINIT = 17'h00800,
        S_CDIV  = 17'h01000,
        S_ACC   = 17'h02000,
        S_AINIT = 17'h04000,
        S_ATAN  = 17'h08000,
        S_OUT   = 17'h10000
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_START,
        OP_DIFF,
        OP_SQX,
        OP_SQY,
        OP_SQRT,
        OP_DINIT,
        OP_DDIV,
        OP_CUBE1,
        OP_CUBE2,
        OP_DEN,
        OP_CINIT,
        OP_CDIV,
        OP_ACC,
        OP_AINIT,
        OP_ATAN,
        OP_OUT
    } t_op;

    typedef struct packed {
        t_op                   op;
        logic [MPS_STEP_W-1:0] step;
        logic [MPS_IDX_W-1:0]  blob;
    } t_cmd;

    typedef struct packed {
        logic       far;
        logic       lit;
        logic [3:0] count;
    } t_status;

    // Rotation angles in units where a right angle is 65536.
    function automatic logic signed [17:0] mps_atan_step(input logic [3:0] i);
        logic signed [17:0] v;
        case (i)
            4'd0:    v = 18'sd32768;
            4'd1:    v = 18'sd19344;
            4'd2:    v = 18'sd10221;
            4'd3:    v = 18'sd5188;
            4'd4:    v = 18'sd2604;
            4'd5:    v = 18'sd1303;
            4'd6:    v = 18'sd652;
            4'd7:    v = 18'sd326;
            4'd8:    v = 18'sd163;
            4'd9:    v = 18'sd81;
            4'd10:   v = 18'sd41;
            4'd11:   v = 18'sd20;
            4'd12:   v = 18'sd10;
            4'd13:   v = 18'sd5;
            4'd14:   v = 18'sd3;
            default: v = 18'sd1;
        endcase
        return v;
    endfunction

endpackage

FILE: src/metaball_pixel_shader_top.sv
// Top level of the metaball pixel shader: controller plus datapath.
// Depends on mps_pkg, mps_ctrl and mps_datapath.
//
// Usage. An item is taken at a rising edge with start high and busy low.
// With i_action low the item loads one blob entry (index, position, strength)
// and busy stays low and no result follows. With i_action high the item shades
// one canvas pixel and busy rises until the result has been produced. The
// result is shown for exactly one cycle with o_valid high; the receiver cannot
// stall it, and the output registers hold the values until the next shaded
// pixel, so a new item may be started in the cycle the result is shown.
// A shade item runs setup; per active blob the square root, a divider and,
// within the distance cut-off, a second divider; then the arctangent when the
// pixel is lit, and output. The per-blob work is set by the bit-serial square
// root (17 steps) and the two restoring dividers (25 and 41 steps).
// Config writes via i_cfg_we, i_cfg_addr, i_cfg_data take effect at once; the
// user must make them only while idle (not enforced by the block). Reset sets
// the default colour, scale and count; the blob table is undefined until loaded.
module metaball_pixel_shader_top
    import mps_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_addr,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_action,
    input  logic [2:0]         i_blob_index,
    input  logic signed [15:0] i_blob_x,
    input  logic signed [15:0] i_blob_y,
    input  logic [8:0]         i_blob_strength,
    input  logic [7:0]         i_pixel_x,
    input  logic [7:0]         i_pixel_y,
    output logic               o_valid,
    output logic [7:0]         o_red,
    output logic [7:0]         o_green,
    output logic [7:0]         o_blue,
    output logic [7:0]         o_white,
    output logic [15:0]        o_field_value,
    output logic               o_lit
);

    t_cmd    w_cmd;
    t_status w_status;

    mps_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_action (i_action),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .o_busy   (busy)
    );

    mps_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_data      (i_cfg_data),
        .i_blob_index    (i_blob_index),
        .i_blob_x        (i_blob_x),
        .i_blob_y        (i_blob_y),
        .i_blob_strength (i_blob_strength),
        .i_pixel_x       (i_pixel_x),
        .i_pixel_y       (i_pixel_y),
        .o_valid         (o_valid),
        .o_red           (o_red),
        .o_green         (o_green),
        .o_blue          (o_blue),
        .o_white         (o_white),
        .o_field_value   (o_field_value),
        .o_lit           (o_lit)
    );

endmodule

FILE: src/mps_ctrl.sv
// Sequencer of the metaball shader: walks the blobs and the iterative units.
// Depends on mps_pkg; drives mps_datapath through t_cmd.
module mps_ctrl
    import mps_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  logic    i_action,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_busy
);

    t_state                r_state, n_state;
    logic [MPS_STEP_W-1:0] r_cnt, n_cnt;
    logic [MPS_IDX_W-1:0]  r_k, n_k;
    logic                  w_more;

    assign w_more = (4'({1'b0, r_k}) + 4'd1) < i_status.count;
    assign o_busy = (r_state != S_IDLE);

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_k        = r_k;
        o_cmd.op   = OP_NONE;
        o_cmd.step = r_cnt;
        o_cmd.blob = r_k;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_action) begin
                        o_cmd.op = OP_START;
                        n_k      = '0;
                        n_state  = (i_status.count == 4'd0) ? S_AINIT : S_DIFF;
                    end else begin
                        o_cmd.op = OP_LOAD;
                    end
                end
            end
            S_DIFF: begin
                o_cmd.op = OP_DIFF;
                n_state  = S_SQX;
            end
            S_SQX: begin
                o_cmd.op = OP_SQX;
                n_state  = S_SQY;
            end
            S_SQY: begin
                o_cmd.op = OP_SQY;
                n_cnt    = '0;
                n_state  = S_SQRT;
            end
            S_SQRT: begin
                o_cmd.op = OP_SQRT;
                if (r_cnt == MPS_SQRT_LAST) begin
                    n_state = S_DINIT;
                end else begin
                    n_cnt = r_cnt + 6'd1;
                end
            end
            S_DINIT: begin
                o_cmd.op = OP_DINIT;
                n_cnt    = '0;
                n_state  = S_DDIV;
            end
            S_DDIV: begin
                o_cmd.op = OP_DDIV;
                if (r_cnt == MPS_DDIV_LAST) begin
                    n_state = S_CHK;
                end else begin
                    n_cnt = r_cnt + 6'd1;
                end
            end
            S_CHK: begin
                // A blob beyond the cut-off distance adds nothing.
                if (!i_status.far) begin
                    n_state = S_CUBE1;
                end else if (w_more) begin
                    n_k     = r_k + 1'b1;
                    n_state = S_DIFF;
                end else begin
                    n_state = S_AINIT;
                end
            end
            S_CUBE1: begin
                o_cmd.op = OP_CUBE1;
                n_state  = S_CUBE2;
            end
            S_CUBE2: begin
                o_cmd.op = OP_CUBE2;
                n_state  = S_DEN;
            end
            S_DEN: begin
                o_cmd.op = OP_DEN;
                n_state  = S_CINIT;
            end
            S_CINIT: begin
                o_cmd.op = OP_CINIT;
                n_cnt    = '0;
                n_state  = S_CDIV;
            end
            S_CDIV: begin
                o_cmd.op = OP_CDIV;
                if (r_cnt == MPS_CDIV_LAST) begin
                    n_state = S_ACC;
                end else begin
                    n_cnt = r_cnt + 6'd1;
                end
            end
            S_ACC: begin
                o_cmd.op = OP_ACC;
                if (w_more) begin
                    n_k     = r_k + 1'b1;
                    n_state = S_DIFF;
                end else begin
                    n_state = S_AINIT;
                end
            end
            S_AINIT: begin
                o_cmd.op = OP_AINIT;
                n_cnt    = '0;
                n_state  = i_status.lit ? S_ATAN : S_OUT;
            end
            S_ATAN: begin
                o_cmd.op = OP_ATAN;
                if (r_cnt == MPS_ATAN_LAST) begin
                    n_state = S_OUT;
                end else begin
                    n_cnt = r_cnt + 6'd1;
                end
            end
            S_OUT: begin
                o_cmd.op = OP_OUT;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_k     <= n_k;
        end
    end

endmodule

FILE: src/mps_datapath.sv
// Datapath of the metaball shader: blob table, configuration registers, square
// root, two restoring dividers, CORDIC arctangent and colour scaling. Uses mps_pkg.
module mps_datapath
    import mps_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_status             o_status,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_addr,
    input  logic [31:0]         i_cfg_data,
    input  logic [2:0]          i_blob_index,
    input  logic signed [15:0]  i_blob_x,
    input  logic signed [15:0]  i_blob_y,
    input  logic [8:0]          i_blob_strength,
    input  logic [7:0]          i_pixel_x,
    input  logic [7:0]          i_pixel_y,
    output logic                o_valid,
    output logic [7:0]          o_red,
    output logic [7:0]          o_green,
    output logic [7:0]          o_blue,
    output logic [7:0]          o_white,
    output logic [15:0]         o_field_value,
    output logic                o_lit
);

    logic [31:0] r_color;
    logic [11:0] r_scale;
    logic [3:0]  r_count;
    logic        r_valid;

    logic signed [15:0] r_bx [MPS_MAX_BLOBS];
    logic signed [15:0] r_by [MPS_MAX_BLOBS];
    logic [8:0]         r_bs [MPS_MAX_BLOBS];

    logic [15:0]        r_px, r_py;
    logic signed [17:0] r_dx, r_dy;
    logic [33:0]        r_sq, r_v, r_root;
    logic [11:0]        r_drem;
    logic [24:0]        r_dquo;
    logic [27:0]        r_d2;
    logic [42:0]        r_cube;
    logic [51:0]        r_den;
    logic [51:0]        r_crem;
    logic [40:0]        r_cquo;
    logic [15:0]        r_sum;
    logic signed [33:0] r_cx, r_cy;
    logic signed [17:0] r_cz;
    logic [7:0]         r_red, r_green, r_blue, r_white;
    logic [15:0]        r_field;
    logic               r_lit;

    logic [11:0]        w_scale;
    logic               w_lit;
    logic [33:0]        w_sqsum, w_bit, w_rb;
    logic [12:0]        w_dtrial;
    logic [52:0]        w_ctrial;
    logic [15:0]        w_add;
    logic [16:0]        w_accsum;
    logic signed [33:0] w_t, w_xs, w_ys;
    logic [16:0]        w_z;
    logic [13:0]        w_d;

    function automatic logic [7:0] shade(input logic [7:0] c, input logic [16:0] z);
        logic [24:0] p;
        p = 25'(c) * 25'(z) + 25'd32768;
        return p[23:16];
    endfunction

    assign w_scale  = (r_scale == 12'd0) ? 12'd1 : r_scale;
    assign w_lit    = r_sum > MPS_THRESH;
    assign w_d      = r_dquo[13:0];
    assign w_sqsum  = r_sq + 34'(r_dy * r_dy);
    assign w_bit    = 34'd1 << (6'd32 - {i_cmd.step[4:0], 1'b0});
    assign w_rb     = r_root + w_bit;
    assign w_dtrial = {r_drem, r_dquo[24]};
    assign w_ctrial = {r_crem, r_cquo[40]};
    // A zero denominator and an oversized quotient both saturate the step.
    assign w_add    = ((r_den == 52'd0) || (|r_cquo[40:16])) ? MPS_FIELD_MAX : r_cquo[15:0];
    assign w_accsum = 17'(r_sum) + 17'(w_add);
    assign w_t      = $signed(34'(r_sum) * 34'd10) - 34'sd512;
    assign w_xs     = r_cx >>> i_cmd.step[3:0];
    assign w_ys     = r_cy >>> i_cmd.step[3:0];
    assign w_z      = r_cz[17] ? 17'd0 :
                      (r_cz > 18'sd65536) ? 17'd65536 : r_cz[16:0];

    assign o_status.far   = |r_dquo[24:14];
    assign o_status.lit   = w_lit;
    assign o_status.count = (r_count > 4'(MPS_MAX_BLOBS)) ? 4'(MPS_MAX_BLOBS) : r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color <= 32'hFF64C864;
            r_scale <= 12'd384;
            r_count <= 4'd6;
            r_valid <= 1'b0;
        end else begin
            r_valid <= (i_cmd.op == OP_OUT);
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    MPS_REG_COLOR: r_color <= i_cfg_data;
                    MPS_REG_SCALE: r_scale <= i_cfg_data[11:0];
                    MPS_REG_COUNT: r_count <= i_cfg_data[3:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_LOAD: begin
                r_bx[i_blob_index] <= i_blob_x;
                r_by[i_blob_index] <= i_blob_y;
                r_bs[i_blob_index] <= i_blob_strength;
            end
            OP_START: begin
                r_px  <= 16'({i_pixel_x, 8'h00} / MPS_SUPERSAMPLE);
                r_py  <= 16'({i_pixel_y, 8'h00} / MPS_SUPERSAMPLE);
                r_sum <= '0;
            end
            OP_DIFF: begin
                r_dx <= $signed({2'b00, r_px}) - 18'(r_bx[i_cmd.blob]);
                r_dy <= $signed({2'b00, r_py}) - 18'(r_by[i_cmd.blob]);
            end
            OP_SQX: begin
                r_sq <= 34'(r_dx * r_dx);
            end
            OP_SQY: begin
                r_v    <= w_sqsum;
                r_root <= '0;
            end
            OP_SQRT: begin
                if (r_v >= w_rb) begin
                    r_v    <= r_v - w_rb;
                    r_root <= (r_root >> 1) + w_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
            end
            OP_DINIT: begin
                r_dquo <= {r_root[16:0], 8'h00};
                r_drem <= '0;
            end
            OP_DDIV: begin
                if (w_dtrial >= {1'b0, w_scale}) begin
                    r_drem <= 12'(w_dtrial - {1'b0, w_scale});
                    r_dquo <= {r_dquo[23:0], 1'b1};
                end else begin
                    r_drem <= w_dtrial[11:0];
                    r_dquo <= {r_dquo[23:0], 1'b0};
                end
            end
            OP_CUBE1: begin
                r_d2 <= 28'(w_d) * 28'(w_d);
            end
            OP_CUBE2: begin
                r_cube <= 43'(r_d2 * w_d) + 43'({w_d, 16'h0000});
            end
            OP_DEN: begin
                r_den <= 52'(r_cube * r_bs[i_cmd.blob]);
            end
            OP_CINIT: begin
                r_cquo <= 41'd1 << 40;
                r_crem <= '0;
            end
            OP_CDIV: begin
                if (w_ctrial >= {1'b0, r_den}) begin
                    r_crem <= 52'(w_ctrial - {1'b0, r_den});
                    r_cquo <= {r_cquo[39:0], 1'b1};
                end else begin
                    r_crem <= w_ctrial[51:0];
                    r_cquo <= {r_cquo[39:0], 1'b0};
                end
            end
            OP_ACC: begin
                r_sum <= w_accsum[16] ? MPS_FIELD_MAX : w_accsum[15:0];
            end
            OP_AINIT: begin
                r_cx <= 34'sd65536;
                r_cy <= w_t <<< 8;
                r_cz <= '0;
            end
            OP_ATAN: begin
                if (r_cy > 34'sd0) begin
                    r_cx <= r_cx + w_ys;
                    r_cy <= r_cy - w_xs;
                    r_cz <= r_cz + mps_atan_step(i_cmd.step[3:0]);
                end else begin
                    r_cx <= r_cx - w_ys;
                    r_cy <= r_cy + w_xs;
                    r_cz <= r_cz - mps_atan_step(i_cmd.step[3:0]);
                end
            end
            OP_OUT: begin
                r_field <= r_sum;
                r_lit   <= w_lit;
                if (w_lit) begin
                    r_red   <= shade(r_color[15:8], w_z);
                    r_green <= shade(r_color[23:16], w_z);
                    r_blue  <= shade(r_color[7:0], w_z);
                    r_white <= shade(r_color[31:24], w_z);
                end else begin
                    r_red   <= '0;
                    r_green <= '0;
                    r_blue  <= '0;
                    r_white <= '0;
                end
            end
            default: ;
        endcase
    end

    assign o_valid       = r_valid;
    assign o_red         = r_red;
    assign o_green       = r_green;
    assign o_blue        = r_blue;
    assign o_white       = r_white;
    assign o_field_value = r_field;
    assign o_lit         = r_lit;

endmodule

FILE: src/mps_checker.sv
// Port-level checks of the metaball shader, bound to the top level.
// Depends on metaball_pixel_shader_top_defines.svh.
`include "metaball_pixel_shader_top_defines.svh"

module mps_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       i_action,
    input logic       o_valid,
    input logic       o_lit,
    input logic [7:0] o_red,
    input logic [7:0] o_green,
    input logic [7:0] o_blue,
    input logic [7:0] o_white
);

    // A result appears as the block returns to idle, and never twice in a row.
    `MPS_ASSERT_IMPL(a_valid_idle, o_valid, !busy)
    `MPS_ASSERT_NEXT(a_valid_single, o_valid, !o_valid)
    // A shaded pixel keeps the block busy; a load completes at once.
    `MPS_ASSERT_NEXT(a_shade_busy, start && !busy && i_action, busy)
    `MPS_ASSERT_NEXT(a_load_quiet, start && !busy && !i_action, !busy && !o_valid)
    // An unlit pixel is black.
    `MPS_ASSERT_IMPL(a_unlit_black, o_valid && !o_lit,
        (o_red == 8'd0) && (o_green == 8'd0) && (o_blue == 8'd0) && (o_white == 8'd0))

endmodule

bind metaball_pixel_shader_top mps_checker u_mps_checker (.*);
